// ----- rtl/core/lfu_pkg.sv -----
// Shared types and constants for the LFU decay cache.
// Used by lfu_ctrl, lfu_dpath and lfu_decay_cache; no dependencies.
package lfu_pkg;

    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 32;
    localparam int VISIT_BITS     = 32;
    localparam int TIME_BITS      = 32;
    localparam int CAP_BITS       = 7;
    localparam int COUNT_OUT_BITS = 7;
    localparam int ENTRIES_DEF    = 64;

    localparam logic [CAP_BITS-1:0]   CAP_RESET   = 7'd64;
    localparam logic [VISIT_BITS-1:0] VISIT_START = 32'd255;
    localparam logic [VISIT_BITS-1:0] VISIT_MAX   = '1;

    typedef enum logic [2:0] {
        MODE_READ  = 3'd0,
        MODE_PEEK  = 3'd1,
        MODE_WRITE = 3'd2,
        MODE_DEL   = 3'd3,
        MODE_EVICT = 3'd4,
        MODE_FIND  = 3'd5,
        MODE_CLEAR = 3'd6,
        MODE_NOP   = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

    typedef struct packed {
        t_mode                  mode;
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  write_value;
        logic [TIME_BITS-1:0]   now_minutes;
    } t_request;

    typedef struct packed {
        t_status                    status;
        logic [VALUE_BITS-1:0]      read_value;
        logic                       evicted;
        logic [KEY_BITS-1:0]        victim_key;
        logic [COUNT_OUT_BITS-1:0]  entry_count;
        logic [31:0]                hit_count;
        logic [31:0]                miss_count;
    } t_result;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  value;
        logic [VISIT_BITS-1:0]  visits;
        logic [TIME_BITS-1:0]   last;
    } t_entry;

    typedef struct packed {
        logic load;
        logic apply;
    } t_ctrl_cmd;

    typedef struct packed {
        logic scan_done;
    } t_ctrl_stat;

endpackage

// ----- rtl/core/lfu_ctrl.sv -----
// Sequencer for the LFU decay cache: idle, slot scan, apply.
// Depends on lfu_pkg.
module lfu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  lfu_pkg::t_ctrl_stat i_stat,
    output lfu_pkg::t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_SCAN;
                        r_busy  <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (i_stat.scan_done) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = r_busy;
    assign o_cmd.load  = start && !r_busy;
    assign o_cmd.apply = (r_state == S_APPLY);

`ifndef SYNTHESIS
    a_busy_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_state != S_IDLE)) else $error("busy out of step with state");
    a_load_enters_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_SCAN)) else $error("request not taken into scan");
    a_apply_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.apply |=> !o_cmd.apply && !r_busy) else $error("apply longer than one cycle");
`endif

endmodule

// ----- rtl/core/lfu_dpath.sv -----
// Datapath for the LFU decay cache: slot memory, valid bits, scan pipeline,
// update logic and result register. Depends on lfu_pkg.
module lfu_dpath #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lfu_pkg::t_ctrl_cmd              i_cmd,
    output lfu_pkg::t_ctrl_stat             o_stat,
    input  lfu_pkg::t_request               i_request,
    input  logic                            i_cfg_wr_en,
    input  logic [lfu_pkg::CAP_BITS-1:0]    i_cfg_wr_data,
    output logic                            o_result_valid,
    output lfu_pkg::t_result                o_result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    lfu_pkg::t_entry mem [ENTRIES];

    logic [ENTRIES-1:0]             r_valid;
    logic [CW-1:0]                  r_count;
    logic [lfu_pkg::CAP_BITS-1:0]   r_cap;
    logic [31:0]                    r_hits;
    logic [31:0]                    r_misses;
    lfu_pkg::t_request              r_req;

    logic [IW-1:0]                  r_addr;
    logic                           r_issue;
    lfu_pkg::t_entry                r_rd;
    logic                           r_v1;
    logic [IW-1:0]                  r_i1;

    logic                           r_v2;
    logic [IW-1:0]                  r_i2;
    logic                           r_m2;
    logic                           r_sv2;
    logic [lfu_pkg::VISIT_BITS-1:0] r_w2;
    lfu_pkg::t_entry                r_e2;

    logic                           r_fnd;
    logic [IW-1:0]                  r_fnd_idx;
    lfu_pkg::t_entry                r_fnd_ent;
    logic                           r_have;
    logic [IW-1:0]                  r_best_idx;
    logic [lfu_pkg::VISIT_BITS-1:0] r_best_w;
    logic [lfu_pkg::KEY_BITS-1:0]   r_best_key;
    logic                           r_free_have;
    logic [IW-1:0]                  r_free_idx;

    logic                           r_res_vld;
    lfu_pkg::t_result               r_res;

    logic                           s1_match;
    logic [lfu_pkg::TIME_BITS-1:0]  s1_elapsed;
    logic [lfu_pkg::VISIT_BITS-1:0] s1_weight;

    always_comb begin
        s1_match   = r_valid[r_i1] && (r_rd.key == r_req.key);
        s1_elapsed = r_req.now_minutes - r_rd.last;
        s1_weight  = (s1_elapsed > r_rd.visits) ? '0 : (r_rd.visits - s1_elapsed);
    end

    assign o_stat.scan_done = r_v2 && (r_i2 == IW'(ENTRIES - 1));

    // update decode
    logic                           n_wr_en;
    logic [IW-1:0]                  n_wr_idx;
    lfu_pkg::t_entry                n_wr_ent;
    logic                           n_clr_en;
    logic [IW-1:0]                  n_clr_idx;
    logic                           n_set_en;
    logic [CW-1:0]                  n_count;
    logic [31:0]                    n_hits;
    logic [31:0]                    n_misses;
    lfu_pkg::t_result               n_res;
    logic                           n_clear_all;
    logic [ENTRIES-1:0]             n_valid;
    logic [8:0]                     cap9;
    logic [8:0]                     eff_cap;
    logic                           need_evict;

    always_comb begin
        cap9 = 9'(r_cap);
        if (cap9 == 9'd0) begin
            eff_cap = 9'd1;
        end else if (cap9 > 9'(ENTRIES)) begin
            eff_cap = 9'(ENTRIES);
        end else begin
            eff_cap = cap9;
        end
        need_evict = (9'(r_count) >= eff_cap);

        n_wr_en     = 1'b0;
        n_wr_idx    = r_fnd_idx;
        n_wr_ent    = r_fnd_ent;
        n_clr_en    = 1'b0;
        n_clr_idx   = r_best_idx;
        n_set_en    = 1'b0;
        n_count     = r_count;
        n_hits      = r_hits;
        n_misses    = r_misses;
        n_clear_all = 1'b0;
        n_res            = '0;
        n_res.status     = lfu_pkg::ST_OK;

        unique case (r_req.mode)
            lfu_pkg::MODE_READ: begin
                if (r_fnd) begin
                    n_res.read_value = r_fnd_ent.value;
                    n_wr_en          = 1'b1;
                    if (r_fnd_ent.visits != lfu_pkg::VISIT_MAX) begin
                        n_wr_ent.visits = r_fnd_ent.visits + 1'b1;
                    end
                    n_wr_ent.last = r_req.now_minutes;
                    if (r_hits != '1) begin
                        n_hits = r_hits + 1'b1;
                    end
                end else begin
                    n_res.status = lfu_pkg::ST_NOT_FOUND;
                    if (r_misses != '1) begin
                        n_misses = r_misses + 1'b1;
                    end
                end
            end
            lfu_pkg::MODE_PEEK: begin
                if (r_fnd) begin
                    n_res.read_value = r_fnd_ent.value;
                end else begin
                    n_res.status = lfu_pkg::ST_NOT_FOUND;
                end
            end
            lfu_pkg::MODE_WRITE: begin
                n_wr_en = 1'b1;
                if (r_fnd) begin
                    n_wr_ent.value = r_req.write_value;
                end else begin
                    n_wr_ent.key    = r_req.key;
                    n_wr_ent.value  = r_req.write_value;
                    n_wr_ent.visits = lfu_pkg::VISIT_START;
                    n_wr_ent.last   = r_req.now_minutes;
                    n_set_en        = 1'b1;
                    if (need_evict && r_have) begin
                        n_clr_en         = 1'b1;
                        n_res.evicted    = 1'b1;
                        n_res.victim_key = r_best_key;
                        n_wr_idx = (r_free_have && (r_free_idx < r_best_idx)) ?
                                   r_free_idx : r_best_idx;
                    end else begin
                        n_wr_idx = r_free_idx;
                        n_count  = r_count + 1'b1;
                    end
                end
            end
            lfu_pkg::MODE_DEL: begin
                if (r_fnd) begin
                    n_clr_en  = 1'b1;
                    n_clr_idx = r_fnd_idx;
                    n_count   = r_count - 1'b1;
                end else begin
                    n_res.status = lfu_pkg::ST_NOT_FOUND;
                end
            end
            lfu_pkg::MODE_EVICT, lfu_pkg::MODE_FIND: begin
                if (r_have) begin
                    n_res.victim_key = r_best_key;
                    if (r_req.mode == lfu_pkg::MODE_EVICT) begin
                        n_clr_en      = 1'b1;
                        n_res.evicted = 1'b1;
                        n_count       = r_count - 1'b1;
                    end
                end else begin
                    n_res.status = lfu_pkg::ST_EMPTY;
                end
            end
            lfu_pkg::MODE_CLEAR: begin
                n_clear_all = 1'b1;
                n_count     = '0;
                n_hits      = '0;
                n_misses    = '0;
            end
            default: begin
            end
        endcase

        n_valid = r_valid;
        if (n_clear_all) begin
            n_valid = '0;
        end else begin
            if (n_clr_en) begin
                n_valid[n_clr_idx] = 1'b0;
            end
            if (n_set_en) begin
                n_valid[n_wr_idx] = 1'b1;
            end
        end

        n_res.entry_count = lfu_pkg::COUNT_OUT_BITS'(n_count);
        n_res.hit_count   = n_hits;
        n_res.miss_count  = n_misses;
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (r_issue) begin
            r_rd <= mem[r_addr];
        end
        if (i_cmd.apply && n_wr_en) begin
            mem[n_wr_idx] <= n_wr_ent;
        end
    end

    // payload and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_request;
        end
        r_i1 <= r_addr;
        r_i2 <= r_i1;
        r_m2 <= s1_match;
        r_sv2 <= r_valid[r_i1];
        r_w2 <= s1_weight;
        r_e2 <= r_rd;
        if (r_v2) begin
            if (r_m2 && !r_fnd) begin
                r_fnd_idx <= r_i2;
                r_fnd_ent <= r_e2;
            end
            if (r_sv2 && (!r_have || (r_w2 < r_best_w))) begin
                r_best_idx <= r_i2;
                r_best_w   <= r_w2;
                r_best_key <= r_e2.key;
            end
            if (!r_sv2 && !r_free_have) begin
                r_free_idx <= r_i2;
            end
        end
        if (i_cmd.apply) begin
            r_res <= n_res;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_count     <= '0;
            r_cap       <= lfu_pkg::CAP_RESET;
            r_hits      <= '0;
            r_misses    <= '0;
            r_addr      <= '0;
            r_issue     <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_fnd       <= 1'b0;
            r_have      <= 1'b0;
            r_free_have <= 1'b0;
            r_res_vld   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_v1      <= r_issue;
            r_v2      <= r_v1;
            r_res_vld <= i_cmd.apply;
            if (i_cmd.load) begin
                r_addr      <= '0;
                r_issue     <= 1'b1;
                r_fnd       <= 1'b0;
                r_have      <= 1'b0;
                r_free_have <= 1'b0;
            end else if (r_issue) begin
                if (r_addr == IW'(ENTRIES - 1)) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (r_v2) begin
                if (r_m2) begin
                    r_fnd <= 1'b1;
                end
                if (r_sv2) begin
                    r_have <= 1'b1;
                end
                if (!r_sv2) begin
                    r_free_have <= 1'b1;
                end
            end
            if (i_cmd.apply) begin
                r_count  <= n_count;
                r_hits   <= n_hits;
                r_misses <= n_misses;
                r_valid  <= n_valid;
            end
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_res;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_count)) else $error("live count out of step");
    a_result_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid == $past(i_cmd.apply)) else $error("result strobe not after apply");
    a_scan_done_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.scan_done |=> !o_stat.scan_done) else $error("scan done held");
`endif

endmodule

// ----- rtl/core/lfu_decay_cache.sv -----
// LFU decay cache top level: sequencer plus datapath. Depends on lfu_pkg.
// Every request scans each slot through the single read port of the slot memory,
// one slot per cycle; a new request is taken only while the block is not busy.
// Reset (synchronous, active low) empties the cache, zeroes hit and miss
// counters and sets capacity to 64. The result receiver cannot stall.
module lfu_decay_cache #(
    parameter int ENTRIES = lfu_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  lfu_pkg::t_request               i_request,
    input  logic                            i_cfg_wr_en,
    input  logic [lfu_pkg::CAP_BITS-1:0]    i_cfg_wr_data,
    output logic                            o_result_valid,
    output lfu_pkg::t_result                o_result
);

    lfu_pkg::t_ctrl_cmd  cmd;
    lfu_pkg::t_ctrl_stat stat;

    lfu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    lfu_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_request      (i_request),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule
